// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every rising clock edge
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// expression must never be true
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ===== src/fsf_pkg.sv =====
// ----------------------------------------------------------------------------
// fsf_pkg
// shared constants, types and tap decode functions of the flame stencil filter
// ----------------------------------------------------------------------------
package fsf_pkg;

	localparam int FRAME_WIDTH  = 256;
	localparam int FRAME_HEIGHT = 256;
	localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int LAG          = 2 * FRAME_WIDTH + 2;

	localparam int LINE_DEPTH = FRAME_WIDTH - 1;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);

	localparam int CNT_W = $clog2(FRAME_PIXELS + LAG);
	localparam int POS_W = $clog2(FRAME_PIXELS);
	localparam int OFF_W = $clog2(2 * FRAME_WIDTH + 3) + 1;

	localparam int WIN_ROWS   = 5;
	localparam int WIN_COLS   = 5;
	localparam int NUM_TAPS   = 4;
	localparam int NUM_DIGITS = 5;
	localparam int DIGIT_BASE = 9;
	localparam int STEP_W     = $clog2(NUM_DIGITS + 1);

	localparam int PIX_W = 8;
	localparam int SUM_W = PIX_W + 2;

	localparam int CODE_W     = 16;
	localparam int QUOT_W     = CODE_W - 3;
	localparam int MUL_W      = 32;
	localparam int DIV9_MUL   = 58255;
	localparam int DIV9_SHIFT = 19;

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TAP_CODE  = 1'b0,
		CFG_SUM_WRAPS = 1'b1
	} cfg_reg_t;

	typedef logic [PIX_W-1:0]        pix_t;
	typedef logic [3:0]              digit_t;
	typedef logic [2:0]              win_idx_t;
	typedef logic signed [OFF_W-1:0] off_t;

	typedef pix_t [WIN_COLS-1:0]   win_row_t;
	typedef win_row_t [WIN_ROWS-1:0] win_t;

	typedef struct packed {
		win_idx_t row;
		win_idx_t col;
		off_t     off;
	} tap_sel_t;

	typedef tap_sel_t [NUM_TAPS-1:0] tap_sel_arr_t;
	typedef digit_t [NUM_DIGITS-1:0] digit_arr_t;

	// row of a 3x3 position, 0 is the row above
	function automatic logic [1:0] digit_row(digit_t d);
		logic [1:0] r;
		unique case (d)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			4'd6, 4'd7, 4'd8: r = 2'd2;
			default:          r = 2'd0;
		endcase
		return r;
	endfunction

	// column of a 3x3 position, 0 is the column to the left
	function automatic logic [1:0] digit_col(digit_t d);
		logic [1:0] c;
		unique case (d)
			4'd0, 4'd3, 4'd6: c = 2'd0;
			4'd1, 4'd4, 4'd7: c = 2'd1;
			4'd2, 4'd5, 4'd8: c = 2'd2;
			default:          c = 2'd0;
		endcase
		return c;
	endfunction

	// window position and linear offset of one tap plus the shared shift
	function automatic tap_sel_t tap_select(digit_t tap_d, digit_t shift_d);
		tap_sel_t s;
		int       r;
		int       c;
		r     = int'(digit_row(tap_d)) + int'(digit_row(shift_d)) - 2;
		c     = int'(digit_col(tap_d)) + int'(digit_col(shift_d)) - 2;
		s.row = win_idx_t'(2 - r);
		s.col = win_idx_t'(2 - c);
		s.off = off_t'(r * FRAME_WIDTH + c);
		return s;
	endfunction

endpackage

// ===== src/fsf_in_if.sv =====
// ----------------------------------------------------------------------------
// fsf_in_if
// source pixel channel, one transfer per source pixel or flush item
// ----------------------------------------------------------------------------
interface fsf_in_if;
	import fsf_pkg::*;

	logic valid;
	logic ready;
	pix_t in_pixel;
	logic is_flush;

	modport source (output valid, output in_pixel, output is_flush, input ready);
	modport sink (input valid, input in_pixel, input is_flush, output ready);

endinterface

// ===== src/fsf_out_if.sv =====
// ----------------------------------------------------------------------------
// fsf_out_if
// result pixel channel, one transfer per new frame pixel
// ----------------------------------------------------------------------------
interface fsf_out_if;
	import fsf_pkg::*;

	logic valid;
	logic ready;
	pix_t out_pixel;
	logic frame_last;

	modport source (output valid, output out_pixel, output frame_last, input ready);
	modport sink (input valid, input out_pixel, input frame_last, output ready);

endinterface

// ===== src/fsf_line_buf.sv =====
// ----------------------------------------------------------------------------
// fsf_line_buf
// single port ring memory of one line delay, read before write, registered read
// ----------------------------------------------------------------------------
module fsf_line_buf (
	input  logic                        clk,
	input  logic                        en,
	input  logic [fsf_pkg::LINE_AW-1:0] addr,
	input  fsf_pkg::pix_t               wdata,
	output fsf_pkg::pix_t               rdata
);
	import fsf_pkg::*;

	pix_t mem [LINE_DEPTH];
	pix_t rd_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rd_q      <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	assign rdata = rd_q;

endmodule

// ===== src/fsf_window.sv =====
// ----------------------------------------------------------------------------
// fsf_window
// 5x5 raster window: four line buffers feeding five-tap shift rows
// ----------------------------------------------------------------------------
module fsf_window (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  fsf_pkg::pix_t pixel,
	output fsf_pkg::win_t win
);
	import fsf_pkg::*;

	logic [LINE_AW-1:0] ptr_q;
	pix_t               head_s1;
	pix_t               shift_s1 [WIN_ROWS][1:WIN_COLS-1];
	pix_t               win_a    [WIN_ROWS][WIN_COLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (en) begin
			ptr_q <= (ptr_q == LINE_AW'(LINE_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
		end
	end

	// column taps of every row
	always_ff @(posedge clk) begin
		if (en) begin
			head_s1 <= pixel;
			for (int a = 0; a < WIN_ROWS; a++) begin
				for (int b = 1; b < WIN_COLS; b++) begin
					shift_s1[a][b] <= win_a[a][b-1];
				end
			end
		end
	end

	genvar ga;
	genvar gb;
	generate
		for (ga = 0; ga < WIN_ROWS; ga++) begin : g_row
			if (ga == 0) begin : g_head
				assign win_a[0][0] = head_s1;
			end else begin : g_line
				fsf_line_buf u_line (
					.clk   (clk),
					.en    (en),
					.addr  (ptr_q),
					.wdata (win_a[ga-1][0]),
					.rdata (win_a[ga][0])
				);
			end
			for (gb = 1; gb < WIN_COLS; gb++) begin : g_col
				assign win_a[ga][gb] = shift_s1[ga][gb];
			end
		end
	endgenerate

	always_comb begin
		for (int a = 0; a < WIN_ROWS; a++) begin
			for (int b = 0; b < WIN_COLS; b++) begin
				win[a][b] = win_a[a][b];
			end
		end
	end

endmodule

// ===== src/fsf_tap_decode.sv =====
// ----------------------------------------------------------------------------
// fsf_tap_decode
// splits the tap code into base-9 digits, one per cycle, and keeps tap selects
// ----------------------------------------------------------------------------
module fsf_tap_decode (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [fsf_pkg::CODE_W-1:0] code,
	output logic                       busy,
	output fsf_pkg::tap_sel_arr_t      sel
);
	import fsf_pkg::*;

	logic [CODE_W-1:0] work_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	digit_arr_t        digit_q;
	tap_sel_arr_t      sel_q;

	logic [MUL_W-1:0]  prod;
	logic [QUOT_W-1:0] quot;
	logic [CODE_W-1:0] times9;
	logic [CODE_W-1:0] rem;
	logic              fix;
	digit_t            digit;
	logic [QUOT_W-1:0] quot_fix;

	// divide by nine through the reciprocal, then one correction step
	always_comb begin
		prod     = MUL_W'(work_q) * MUL_W'(DIV9_MUL);
		quot     = prod[DIV9_SHIFT +: QUOT_W];
		times9   = {quot, 3'b000} + CODE_W'(quot);
		rem      = work_q - times9;
		fix      = rem >= CODE_W'(DIGIT_BASE);
		digit    = fix ? digit_t'(rem - CODE_W'(DIGIT_BASE)) : digit_t'(rem);
		quot_fix = fix ? quot + 1'b1 : quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q  <= '0;
			step_q  <= '0;
			busy_q  <= 1'b0;
			digit_q <= '0;
		end else if (load) begin
			work_q <= code;
			step_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (step_q == STEP_W'(NUM_DIGITS)) begin
				busy_q <= 1'b0;
			end else begin
				digit_q <= {digit, digit_q[NUM_DIGITS-1:1]};
				work_q  <= CODE_W'(quot_fix);
				step_q  <= step_q + 1'b1;
			end
		end
	end

	// lowest digit is the shift, the next four are the taps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_TAPS; k++) begin
				sel_q[k] <= tap_select('0, '0);
			end
		end else begin
			for (int k = 0; k < NUM_TAPS; k++) begin
				sel_q[k] <= tap_select(digit_q[k+1], digit_q[0]);
			end
		end
	end

	assign busy = busy_q;
	assign sel  = sel_q;

endmodule

// ===== src/fsf_tap_sum.sv =====
// ----------------------------------------------------------------------------
// fsf_tap_sum
// picks four window taps, zeroes out-of-range positions, sums and decays
// ----------------------------------------------------------------------------
module fsf_tap_sum (
	input  fsf_pkg::win_t             win,
	input  fsf_pkg::tap_sel_arr_t     sel,
	input  logic [fsf_pkg::POS_W-1:0] pos,
	input  logic                      wraps,
	output fsf_pkg::pix_t             result
);
	import fsf_pkg::*;

	localparam int Q_W = POS_W + 2;

	logic signed [Q_W-1:0] tap_pos [NUM_TAPS];
	logic                  tap_in  [NUM_TAPS];
	pix_t                  tap_val [NUM_TAPS];
	logic [SUM_W-1:0]      sum;
	logic [SUM_W-1:0]      sum_cut;
	pix_t                  quarter;

	always_comb begin
		sum = '0;
		for (int k = 0; k < NUM_TAPS; k++) begin
			tap_pos[k] = $signed({2'b00, pos}) + Q_W'(sel[k].off);
			tap_in[k]  = !tap_pos[k][Q_W-1] && (tap_pos[k] < $signed(Q_W'(FRAME_PIXELS)));
			tap_val[k] = tap_in[k] ? win[sel[k].row][sel[k].col] : '0;
			sum        = sum + SUM_W'(tap_val[k]);
		end
		sum_cut = wraps ? {2'b00, sum[PIX_W-1:0]} : sum;
		quarter = sum_cut[SUM_W-1:2];
		result  = (quarter == '0) ? '0 : quarter - 1'b1;
	end

endmodule

// ===== src/flame_stencil_filter.sv =====
// ----------------------------------------------------------------------------
// flame_stencil_filter
// fire effect step: four-tap 3x3 stencil average with decay on a pixel stream
// ----------------------------------------------------------------------------
//  port        dir  handshake     payload
//  prev_frame  in   valid/ready   in_pixel[7:0], is_flush
//  next_frame  out  valid/ready   out_pixel[7:0], frame_last
//  cfg         in   cfg_write     cfg_index[0], cfg_data[15:0]
//
//  one pixel per clock while ready; results go via stage one to the result register
//  result of frame position p comes with item p+2W+2 (four line buffers of W-1)
//  a tap_code write holds prev_frame ready low for digit extraction
//  reset clears counters and valids, line buffer contents are left as is
//  a stalled next_frame holds one result plus one item before ready drops
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flame_stencil_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [fsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsf_pkg::CODE_W-1:0]    cfg_data,
	fsf_in_if.sink                        prev_frame,
	fsf_out_if.source                     next_frame
);
	import fsf_pkg::*;

	logic             busy;
	tap_sel_arr_t     sel;
	win_t             win;
	pix_t             pixel;
	pix_t             result;
	logic             wraps_q;
	logic [CNT_W-1:0] n_q;

	logic             vld_s1;
	logic             res_s1;
	logic             last_s1;
	logic [POS_W-1:0] pos_s1;

	logic             out_vld_q;
	pix_t             out_pix_q;
	logic             out_last_q;

	logic             in_fire;
	logic             out_free;
	logic             s1_go;
	logic             out_load;
	logic             res_next;
	logic             last_next;
	logic [POS_W-1:0] pos_next;

	assign out_free         = !out_vld_q || next_frame.ready;
	assign s1_go            = vld_s1 && (!res_s1 || out_free);
	assign out_load         = vld_s1 && res_s1 && out_free;
	assign prev_frame.ready = !busy && (!vld_s1 || !res_s1 || out_free);
	assign in_fire          = prev_frame.valid && prev_frame.ready;
	assign pixel            = prev_frame.is_flush ? '0 : prev_frame.in_pixel;

	assign res_next  = n_q >= CNT_W'(LAG);
	assign pos_next  = POS_W'(n_q - CNT_W'(LAG));
	assign last_next = res_next && (pos_next == POS_W'(FRAME_PIXELS - 1));

	fsf_tap_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (cfg_write && (cfg_reg_t'(cfg_index) == CFG_TAP_CODE)),
		.code   (cfg_data),
		.busy   (busy),
		.sel    (sel)
	);

	fsf_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (in_fire),
		.pixel  (pixel),
		.win    (win)
	);

	fsf_tap_sum u_sum (
		.win    (win),
		.sel    (sel),
		.pos    (pos_s1),
		.wraps  (wraps_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wraps_q <= 1'b0;
		end else if (cfg_write && (cfg_reg_t'(cfg_index) == CFG_SUM_WRAPS)) begin
			wraps_q <= cfg_data[0];
		end
	end

	// frame position counter and stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			vld_s1  <= 1'b0;
			res_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else if (in_fire) begin
			n_q     <= last_next ? '0 : n_q + 1'b1;
			vld_s1  <= 1'b1;
			res_s1  <= res_next;
			last_s1 <= last_next;
		end else if (s1_go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pos_s1 <= pos_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (next_frame.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pix_q  <= result;
			out_last_q <= last_s1;
		end
	end

	assign next_frame.valid      = out_vld_q;
	assign next_frame.out_pixel  = out_pix_q;
	assign next_frame.frame_last = out_last_q;

	`ASSERT_PROP(a_hold_stalled, vld_s1 && res_s1 && !out_free |=> vld_s1 && $stable(pos_s1), "stalled item lost")
	`ASSERT_PROP(a_last_has_res, vld_s1 && last_s1 |-> res_s1, "frame end without a result")
	`ASSERT_PROP(a_count_range, n_q <= CNT_W'(FRAME_PIXELS + LAG - 1), "item counter out of range")
	`ASSERT_NEVER(a_no_take_busy, in_fire && busy, "transfer during tap decode")
	`ASSERT_PROP(a_load_result, out_load |=> out_vld_q && (next_frame.out_pixel == $past(result)), "result not loaded")

endmodule

// ===== test/flame_stencil_filter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flame_stencil_filter_test
// streams source pixels through the stencil filter under random idling on
// both channels, predicts each new pixel from its own window of recent pixels
// and compares every result transfer in order; covers warm-up, flushes,
// every tap code region and both sum modes
// ----------------------------------------------------------------------------
module flame_stencil_filter_test;
	import fsf_pkg::*;

	localparam int RING_DEPTH    = 4 * FRAME_WIDTH + 5;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int MAX_REPORTS   = 100;
	localparam int CODE_MAX      = 59048;
	localparam int CENTER_CODE   = 29524;

	typedef struct {
		pix_t pixel;
		logic flush;
	} src_item_t;

	typedef struct {
		pix_t pixel;
		logic last;
	} new_pixel_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CODE_W-1:0]    cfg_data;

	fsf_in_if  prev_frame ();
	fsf_out_if next_frame ();

	flame_stencil_filter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.prev_frame (prev_frame),
		.next_frame (next_frame)
	);

	src_item_t   pixel_queue[$];
	new_pixel_t  expected_pixels[$];
	pix_t        recent_pixels[RING_DEPTH];
	int unsigned frame_pos;
	logic [CODE_W-1:0] tap_code_q;
	logic        sum_wraps_q;
	int          errors;
	int          send_gap;
	int          recv_gap;
	int          hold_left;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          long_gaps;
	bit          hold_request;
	int          rx_gap;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int next_gap(int pct, bit allow_long);
		int r;
		if ($urandom_range(0, 99) >= pct)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 97 || !allow_long)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// linear offset of a 3x3 position
	function automatic int tap_offset(int digit);
		return (digit / 3 - 1) * FRAME_WIDTH + (digit % 3 - 1);
	endfunction

	function automatic int tap_value(int q);
		if (q < 0 || q >= FRAME_PIXELS)
			return 0;
		return int'(recent_pixels[q % RING_DEPTH]);
	endfunction

	function automatic logic [CODE_W-1:0] random_code();
		int code;
		if ($urandom_range(0, 1))
			return CODE_W'($urandom_range(0, 65535));
		code = 0;
		for (int k = 0; k < NUM_DIGITS; k++)
			code = code * DIGIT_BASE + $urandom_range(0, DIGIT_BASE - 1);
		return CODE_W'(code);
	endfunction

	task automatic predict_new_pixel(pix_t px, logic flush);
		int unsigned code;
		int          shift;
		int          sum;
		int          quarter;
		int          p;
		new_pixel_t  np;
		if (frame_pos < FRAME_PIXELS)
			recent_pixels[frame_pos % RING_DEPTH] = flush ? '0 : px;
		if (frame_pos < LAG) begin
			frame_pos++;
			return;
		end
		p     = int'(frame_pos) - LAG;
		code  = tap_code_q;
		shift = tap_offset(code % DIGIT_BASE);
		code  = code / DIGIT_BASE;
		sum   = 0;
		for (int k = 0; k < NUM_TAPS; k++) begin
			sum += tap_value(p + tap_offset(code % DIGIT_BASE) + shift);
			code = code / DIGIT_BASE;
		end
		if (sum_wraps_q)
			sum = sum & 'hFF;
		quarter  = sum >> 2;
		np.pixel = pix_t'(quarter > 0 ? quarter - 1 : 0);
		np.last  = (p == FRAME_PIXELS - 1);
		expected_pixels.push_back(np);
		frame_pos = np.last ? 0 : frame_pos + 1;
	endtask

	task automatic check_new_pixel(pix_t px, logic last);
		new_pixel_t want;
		if (expected_pixels.size() == 0) begin
			if (errors < MAX_REPORTS)
				$display("%0t: unexpected result out_pixel=%0d frame_last=%0d", $time, px, last);
			errors++;
			return;
		end
		want = expected_pixels.pop_front();
		if (px !== want.pixel) begin
			if (errors < MAX_REPORTS)
				$display("%0t: out_pixel expected %0d actual %0d", $time, want.pixel, px);
			errors++;
		end
		if (last !== want.last) begin
			if (errors < MAX_REPORTS)
				$display("%0t: frame_last expected %0d actual %0d", $time, want.last, last);
			errors++;
		end
	endtask

	// source side
	always @(posedge clk) begin
		if (!arst_n) begin
			prev_frame.valid <= 1'b0;
		end else if (!prev_frame.valid || prev_frame.ready) begin
			if (send_gap > 0) begin
				send_gap         <= send_gap - 1;
				prev_frame.valid <= 1'b0;
			end else if (pixel_queue.size() > 0) begin
				prev_frame.in_pixel <= pixel_queue[0].pixel;
				prev_frame.is_flush <= pixel_queue[0].flush;
				prev_frame.valid    <= 1'b1;
				send_gap            <= next_gap(send_idle_pct, long_gaps);
				void'(pixel_queue.pop_front());
			end else begin
				prev_frame.valid <= 1'b0;
			end
		end
	end

	// result side, with the long hold-off counted here
	always @(posedge clk) begin
		if (!arst_n) begin
			next_frame.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left        <= hold_left - 1;
			next_frame.ready <= 1'b0;
		end else if (hold_request) begin
			hold_request      = 1'b0;
			hold_left        <= HOLD_CYCLES;
			next_frame.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap         <= recv_gap - 1;
			next_frame.ready <= 1'b0;
		end else if (!next_frame.ready || next_frame.valid) begin
			rx_gap            = next_gap(recv_idle_pct, long_gaps);
			next_frame.ready <= (rx_gap == 0);
			recv_gap         <= rx_gap > 0 ? rx_gap - 1 : 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (prev_frame.valid && prev_frame.ready)
				predict_new_pixel(prev_frame.in_pixel, prev_frame.is_flush);
			if (next_frame.valid && next_frame.ready)
				check_new_pixel(next_frame.out_pixel, next_frame.frame_last);
		end
	end

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pixel_queue.size() != 0 || prev_frame.valid || expected_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CODE_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == CFG_TAP_CODE)
			tap_code_q = value;
		else
			sum_wraps_q = value[0];
	endtask

	task automatic configure(logic [CODE_W-1:0] code, logic wraps);
		wait_idle();
		if ($urandom_range(0, 1)) begin
			write_reg(CFG_TAP_CODE, code);
			write_reg(CFG_SUM_WRAPS, CODE_W'(wraps));
		end else begin
			write_reg(CFG_SUM_WRAPS, CODE_W'(wraps));
			write_reg(CFG_TAP_CODE, code);
		end
		@(negedge clk);
	endtask

	task automatic push_one(pix_t px, logic flush);
		src_item_t it;
		it.pixel = px;
		it.flush = flush;
		pixel_queue.push_back(it);
	endtask

	task automatic push_items(int n, int flush_pct);
		int   r;
		pix_t px;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				px = '0;
			else if (r == 1)
				px = '1;
			else
				px = pix_t'($urandom_range(0, 255));
			push_one(px, $urandom_range(0, 99) < flush_pct);
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_write           = 1'b0;
		cfg_index           = CFG_TAP_CODE;
		cfg_data            = '0;
		prev_frame.valid    = 1'b0;
		prev_frame.in_pixel = '0;
		prev_frame.is_flush = 1'b0;
		next_frame.ready    = 1'b0;
		frame_pos           = 0;
		tap_code_q          = '0;
		sum_wraps_q         = 1'b0;
		errors              = 0;
		send_gap            = 0;
		recv_gap            = 0;
		hold_left           = 0;
		hold_request        = 1'b0;
		send_idle_pct       = 20;
		recv_idle_pct       = 20;
		long_gaps           = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, bit patterns and flushes inside the frame
		configure(CODE_W'(CENTER_CODE), 1'b0);
		push_one(8'h00, 1'b0);
		push_one(8'hFF, 1'b0);
		push_one(8'h01, 1'b0);
		push_one(8'h80, 1'b0);
		push_one(8'hAA, 1'b0);
		push_one(8'h55, 1'b0);
		push_one(8'hFF, 1'b1);
		push_one(8'h00, 1'b1);
		push_one(8'hFE, 1'b0);
		push_one(8'h7F, 1'b0);
		push_one(8'h0F, 1'b0);
		push_one(8'hF0, 1'b0);
		push_one(8'hFF, 1'b0);
		push_one(8'hFF, 1'b0);
		push_one(8'hFF, 1'b0);
		push_one(8'h02, 1'b0);
		push_one(8'h04, 1'b0);
		push_one(8'h08, 1'b0);
		push_one(8'h10, 1'b0);
		push_one(8'h20, 1'b0);
		push_one(8'h40, 1'b0);
		push_one(8'h03, 1'b0);
		push_one(8'h5A, 1'b1);

		// random phases over the tap code regions and both sum modes
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0:       configure(CODE_W'(CENTER_CODE), 1'b1);
				1:       configure(CODE_W'(CODE_MAX), 1'b0);
				2:       configure(16'hFFFF, 1'b1);
				3:       configure(16'h0000, 1'b0);
				4:       configure(CODE_W'(CODE_MAX + 1), 1'b1);
				default: configure(random_code(), ph[0]);
			endcase
			send_idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 25 : 60;
			recv_idle_pct = (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 60 : 25;
			if (ph == 5) begin
				send_idle_pct = 0;
				hold_request  = 1'b1;
			end
			push_items(165, 6);
		end

		wait_idle();
		if (errors == 0)
			$display("flame_stencil_filter_test: done, clean");
		else
			$display("flame_stencil_filter_test: done, errors");
		$finish;
	end

	initial begin
		#(80_000_000);
		$display("flame_stencil_filter_test: done, errors");
		$finish;
	end

endmodule
